// ===== hw/rtl/crnc_pkg.sv =====
// ----------------------------------------------------------------------------
// crnc_pkg
// Shared constants, codes and types of the chaos representation quantizer.
// ----------------------------------------------------------------------------
package crnc_pkg;

  localparam int unsigned DIMS    = 4;
  localparam int unsigned CODES   = 8;
  localparam int unsigned SYMBOLS = 16;

  localparam int unsigned DIM_W   = 2;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned DIST_W  = 34;

  localparam int unsigned CORNER_AW = SYM_W + DIM_W;
  localparam int unsigned CODE_AW   = CODE_W + DIM_W;

  localparam logic [COORD_W-1:0] Q_HALF = 16'h8000;
  localparam logic [COORD_W:0]   Q_ONE  = 17'h10000;

  typedef enum logic [1:0] {
    OP_CORNER = 2'd0,
    OP_CODE   = 2'd1,
    OP_STEP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_SHRINK = 2'd0,
    REG_DIMS   = 2'd1,
    REG_CODES  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SRC_RD,
    ST_SRC_SQ,
    ST_SRC_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               corner_en;
    logic               code_en;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  entry;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] val;
  } tbl_wr_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] entry;
    logic [DIM_W-1:0]  dim;
  } tbl_rd_t;

endpackage

// ===== hw/rtl/crnc_tables.sv =====
// ----------------------------------------------------------------------------
// crnc_tables
// Corner and codebook coordinate memories, one write and one registered read.
// ----------------------------------------------------------------------------
module crnc_tables
  import crnc_pkg::*;
(
  input  logic               clk_i,
  input  tbl_wr_t            wr_i,
  input  tbl_rd_t            rd_i,
  output logic [COORD_W-1:0] corner_o,
  output logic [COORD_W-1:0] code_o
);

  logic [COORD_W-1:0] corner_mem [SYMBOLS*DIMS];
  logic [COORD_W-1:0] code_mem   [CODES*DIMS];

  logic [CORNER_AW-1:0] corner_wa, corner_ra;
  logic [CODE_AW-1:0]   code_wa, code_ra;

  assign corner_wa = {wr_i.sym, wr_i.dim};
  assign code_wa   = {wr_i.entry, wr_i.dim};
  assign corner_ra = {rd_i.sym, rd_i.dim};
  assign code_ra   = {rd_i.entry, rd_i.dim};

  always_ff @(posedge clk_i) begin
    if (wr_i.corner_en) begin
      corner_mem[corner_wa] <= wr_i.val;
    end
    corner_o <= corner_mem[corner_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.code_en) begin
      code_mem[code_wa] <= wr_i.val;
    end
    code_o <= code_mem[code_ra];
  end

endmodule

// ===== hw/rtl/chaos_rep_nearest_codebook_top.sv =====
// ----------------------------------------------------------------------------
// chaos_rep_nearest_codebook_top
// Chaos game point update per symbol, nearest codebook search on last symbol.
// ----------------------------------------------------------------------------
// Table write beats are taken in idle and leave the block idle. A symbol beat reads
// the corner memory and updates the point once per active dim (D active dims). A last
// symbol adds a read, square and accumulate per coordinate of each of the C active codes,
// then loads the output register once it is free. One beat is in work at a time.
// Reset centers the point and loads register defaults; tables are undefined
// until written and get no clearing pass.
module chaos_rep_nearest_codebook_top
  import crnc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // symbol[3:0], entry_index[6:4], dim_index[8:7],
                                      // coord_value[24:9], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // nearest_code[2:0], nearest_distance[36:3], zero pad
);

  state_e state_q, state_d;

  logic [15:0] shrink_q;
  logic [2:0]  dims_q;
  logic [3:0]  codes_q;

  logic [SYM_W-1:0]   sym_q;
  logic               last_q;
  logic [DIM_W-1:0]   dim_q;
  logic [CODE_W-1:0]  code_q;
  logic [COORD_W-1:0] pos_q [DIMS];
  logic [SQ_W-1:0]    sq_q;
  logic [DIST_W-1:0]  acc_q, best_q;
  logic [CODE_W-1:0]  best_code_q;
  logic               out_vld_q;
  logic [CODE_W-1:0]  out_code_q;
  logic [DIST_W-1:0]  out_dist_q;

  logic               in_acc, out_free, out_load, dim_end, code_end;
  op_e                in_op;
  logic [DIM_W-1:0]   dim_last;
  logic [CODE_W-1:0]  code_last;
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  logic [COORD_W-1:0] corner_rd, code_rd;

  logic [COORD_W:0]      pull;
  logic [2*COORD_W-1:0]  keep_prod;
  logic [2*COORD_W:0]    pull_prod;
  logic [COORD_W:0]      upd_sum;
  logic [COORD_W-1:0]    upd_pos;
  logic signed [COORD_W:0]     diff;
  logic signed [2*COORD_W+1:0] diff_sq;
  logic [DIST_W-1:0]     acc_sum;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    if (dims_q == 3'd0) begin
      dim_last = '0;
    end else if (dims_q > 3'(DIMS)) begin
      dim_last = DIM_W'(DIMS - 1);
    end else begin
      dim_last = DIM_W'(dims_q - 3'd1);
    end
    if (codes_q == 4'd0) begin
      code_last = '0;
    end else if (codes_q > 4'(CODES)) begin
      code_last = CODE_W'(CODES - 1);
    end else begin
      code_last = CODE_W'(codes_q - 4'd1);
    end
  end

  assign dim_end  = (dim_q == dim_last);
  assign code_end = (code_q == code_last);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_STEP) state_d = ST_UPD_RD;
      end
      ST_UPD_RD:  state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        if (dim_end) state_d = last_q ? ST_SRC_RD : ST_IDLE;
        else         state_d = ST_UPD_RD;
      end
      ST_SRC_RD:  state_d = ST_SRC_SQ;
      ST_SRC_SQ:  state_d = ST_SRC_ACC;
      ST_SRC_ACC: begin
        state_d = (dim_end && code_end) ? ST_DONE : ST_SRC_RD;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready    = (state_q == ST_IDLE);
    out_load         = (state_q == ST_DONE) && out_free;
    tbl_wr.corner_en = 1'b0;
    tbl_wr.code_en   = 1'b0;
    tbl_wr.sym       = s_axis_tdata[3:0];
    tbl_wr.entry     = s_axis_tdata[6:4];
    tbl_wr.dim       = s_axis_tdata[8:7];
    tbl_wr.val       = s_axis_tdata[24:9];
    if (in_acc) begin
      case (in_op)
        OP_CORNER: tbl_wr.corner_en = 1'b1;
        OP_CODE:   tbl_wr.code_en   = 1'b1;
        default:   ;
      endcase
    end
    tbl_rd.sym   = sym_q;
    tbl_rd.entry = code_q;
    tbl_rd.dim   = dim_q;
  end

  crnc_tables u_tables (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .rd_i     (tbl_rd),
    .corner_o (corner_rd),
    .code_o   (code_rd)
  );

  // point update: k*x + (1-k)*corner, each product truncated
  assign pull      = Q_ONE - {1'b0, shrink_q};
  assign keep_prod = shrink_q * pos_q[dim_q];
  assign pull_prod = pull * corner_rd;
  assign upd_sum   = {1'b0, keep_prod[2*COORD_W-1:COORD_W]} + pull_prod[2*COORD_W:COORD_W];
  assign upd_pos   = upd_sum[COORD_W] ? '1 : upd_sum[COORD_W-1:0];

  // distance
  assign diff    = $signed({1'b0, pos_q[dim_q]}) - $signed({1'b0, code_rd});
  assign diff_sq = diff * diff;
  assign acc_sum = ((dim_q == '0) ? '0 : acc_q) + DIST_W'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      shrink_q  <= 16'd32768;
      dims_q    <= 3'd4;
      codes_q   <= 4'd6;
      dim_q     <= '0;
      code_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIMS; i++) pos_q[i] <= Q_HALF;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_SHRINK: shrink_q <= cfg_data_i;
          REG_DIMS:   dims_q   <= cfg_data_i[2:0];
          REG_CODES:  codes_q  <= cfg_data_i[3:0];
          default:    ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          dim_q  <= '0;
          code_q <= '0;
        end
        ST_UPD_WR: begin
          pos_q[dim_q] <= upd_pos;
          dim_q        <= dim_end ? '0 : dim_q + 1'b1;
        end
        ST_SRC_ACC: begin
          if (dim_end) begin
            dim_q  <= '0;
            code_q <= code_end ? '0 : code_q + 1'b1;
          end else begin
            dim_q <= dim_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_vld_q <= 1'b1;
        for (int i = 0; i < DIMS; i++) pos_q[i] <= Q_HALF;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q  <= s_axis_tdata[3:0];
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_SRC_SQ) begin
      sq_q <= diff_sq[SQ_W-1:0];
    end
    if (state_q == ST_SRC_ACC) begin
      acc_q <= acc_sum;
      if (dim_end && (code_q == '0 || acc_sum < best_q)) begin
        best_q      <= acc_sum;
        best_code_q <= code_q;
      end
    end
    if (out_load) begin
      out_code_q <= best_code_q;
      out_dist_q <= best_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_dist_q, out_code_q};

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result valid without finished search");

  a_center_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (pos_q[0] == Q_HALF) && (pos_q[DIMS-1] == Q_HALF))
    else $error("point not centered after result");

  a_dim_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR || state_q == ST_SRC_ACC) |-> dim_q <= dim_last)
    else $error("dimension counter beyond active range");

  a_code_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> best_code_q <= code_last)
    else $error("winning code beyond active range");

endmodule

// ===== dv/tb_chaos_rep_nearest_codebook_top.sv =====
// ----------------------------------------------------------------------------
// tb_chaos_rep_nearest_codebook_top
// Self-checking bench for the chaos game point update and codebook search.
// Loads both tables, runs a short directed list, then random symbol sequences
// with table rewrites and noise under several register settings. A scoreboard
// predicts every nearest-code beat and compares it field by field.
// ----------------------------------------------------------------------------
module tb_chaos_rep_nearest_codebook_top;
  import crnc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned SETTLE     = 120;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned HOLD_AT    = 180;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned PHASE_LEN  = 40;
  localparam logic [1:0]  OP_NONE    = 2'd3;
  localparam logic [1:0]  REG_NONE   = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  entry;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] coord;
    logic               last;
  } beat_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [DIST_W-1:0] sq_dist;
  } match_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  chaos_rep_nearest_codebook_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state and register copies
  logic [COORD_W-1:0] point      [DIMS];
  logic [COORD_W-1:0] corner_mem [SYMBOLS * DIMS];
  logic [COORD_W-1:0] code_mem   [CODES * DIMS];
  logic [15:0]        shrink_q = 16'h8000;
  logic [2:0]         dims_q   = 3'd4;
  logic [3:0]         codes_q  = 4'd6;

  beat_t       pending_beats [$];
  match_t      nearest_q     [$];
  int unsigned accepted_beats = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 18;
  int unsigned recv_idle_pct  = 74;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  initial begin
    for (int d = 0; d < DIMS; d++) point[d] = Q_HALF;
  end

  task automatic quantize_beat(input beat_t b);
    int unsigned nd, nc;
    logic [63:0] keep, pull, mix, d2, best_d;
    longint      diff;
    logic [CODE_W-1:0] best;
    match_t      m;
    nd = (dims_q == 0) ? 1 : (dims_q > DIMS) ? DIMS : dims_q;
    nc = (codes_q == 0) ? 1 : (codes_q > CODES) ? CODES : codes_q;
    best = '0;
    best_d = '0;
    case (b.op)
      OP_CORNER: corner_mem[b.sym * DIMS + b.dim] = b.coord;
      OP_CODE:   code_mem[b.entry * DIMS + b.dim] = b.coord;
      OP_STEP: begin
        keep = 64'(shrink_q);
        pull = 64'h10000 - keep;
        for (int d = 0; d < nd; d++) begin
          mix = ((keep * 64'(point[d])) >> 16)
              + ((pull * 64'(corner_mem[b.sym * DIMS + d])) >> 16);
          point[d] = (mix > 64'hFFFF) ? 16'hFFFF : mix[15:0];
        end
        if (b.last) begin
          for (int c = 0; c < nc; c++) begin
            d2 = '0;
            for (int d = 0; d < nd; d++) begin
              diff = longint'(point[d]) - longint'(code_mem[c * DIMS + d]);
              d2 = d2 + 64'(diff * diff);
              if (d2 > 64'h3_FFFF_FFFF) d2 = 64'h3_FFFF_FFFF;
            end
            if (c == 0 || d2 < best_d) begin
              best_d = d2;
              best = CODE_W'(c);
            end
          end
          m.code    = best;
          m.sq_dist = best_d[DIST_W-1:0];
          nearest_q = {nearest_q, m};
          for (int d = 0; d < DIMS; d++) point[d] = Q_HALF;
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        quantize_beat(pending_beats.pop_front());
        accepted_beats++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (pending_beats.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, b.coord, b.dim, b.entry, b.sym};
        s_axis_tuser  <= b.op;
        s_axis_tlast  <= b.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v, act_v, $realtime);
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    match_t exp_m;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (nearest_q.size() == 0) begin
          flag_mismatch("unexpected beat", '0, 64'(m_axis_tdata));
        end else begin
          exp_m = nearest_q.pop_front();
          if (m_axis_tdata[2:0] !== exp_m.code)
            flag_mismatch("nearest_code", 64'(exp_m.code), 64'(m_axis_tdata[2:0]));
          if (m_axis_tdata[36:3] !== exp_m.sq_dist)
            flag_mismatch("nearest_distance", 64'(exp_m.sq_dist), 64'(m_axis_tdata[36:3]));
        end
      end
      if (!hold_done && accepted_beats >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic beat_t rand_beat();
    beat_t b;
    b.op    = 2'($urandom);
    b.sym   = SYM_W'($urandom);
    b.entry = CODE_W'($urandom);
    b.dim   = DIM_W'($urandom);
    b.coord = COORD_W'($urandom);
    b.last  = 1'($urandom);
    return b;
  endfunction

  task automatic push_beat(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] entry, input logic [DIM_W-1:0] dim,
                           input logic [COORD_W-1:0] coord, input logic last);
    beat_t b;
    b.op    = op;
    b.sym   = sym;
    b.entry = entry;
    b.dim   = dim;
    b.coord = coord;
    b.last  = last;
    pending_beats = {pending_beats, b};
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_SHRINK: shrink_q = data;
      REG_DIMS:   dims_q   = data[2:0];
      REG_CODES:  codes_q  = data[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mostly well-formed symbol runs, with table rewrites and noise mixed in
  task automatic queue_random(input int unsigned n);
    int unsigned made, len;
    beat_t b;
    made = 0;
    while (made < n) begin
      case ($urandom_range(9))
        0: begin
          b = rand_beat();
          b.op = OP_NONE;
          pending_beats = {pending_beats, b};
        end
        1, 2: begin
          b = rand_beat();
          b.op = $urandom_range(1) ? OP_CODE : OP_CORNER;
          pending_beats = {pending_beats, b};
          made++;
        end
        default: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            b = rand_beat();
            b.op = OP_STEP;
            b.last = (i == len - 1);
            pending_beats = {pending_beats, b};
          end
          made += len;
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] k;
    logic [2:0]  nd;
    logic [3:0]  nc;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every table entry gets written before any step reads it
    for (int s = 0; s < SYMBOLS; s++)
      for (int d = 0; d < DIMS; d++)
        push_beat(OP_CORNER, SYM_W'(s), 3'($urandom), DIM_W'(d), 16'($urandom), 1'b0);
    for (int e = 0; e < CODES; e++)
      for (int d = 0; d < DIMS; d++)
        push_beat(OP_CODE, 4'($urandom), CODE_W'(e), DIM_W'(d), 16'($urandom), 1'b0);

    push_beat(OP_STEP, 4'd0, 3'd0, 2'd0, 16'h0000, 1'b0);
    push_beat(OP_STEP, 4'd15, 3'd0, 2'd0, 16'h0000, 1'b1);
    push_beat(OP_NONE, 4'd15, 3'd7, 2'd3, 16'hFFFF, 1'b1);
    push_beat(OP_CORNER, 4'd15, 3'd7, 2'd3, 16'hFFFF, 1'b1);
    push_beat(OP_CODE, 4'd0, 3'd7, 2'd0, 16'h0000, 1'b0);
    // centered corner and two equal centered entries: distance tie
    for (int d = 0; d < DIMS; d++)
      push_beat(OP_CORNER, 4'd5, 3'd0, DIM_W'(d), Q_HALF, 1'b0);
    for (int e = 2; e < 4; e++)
      for (int d = 0; d < DIMS; d++)
        push_beat(OP_CODE, 4'd0, CODE_W'(e), DIM_W'(d), Q_HALF, 1'b0);
    push_beat(OP_STEP, 4'd5, 3'd0, 2'd0, 16'h0000, 1'b1);
    push_beat(OP_STEP, 4'd15, 3'd0, 2'd0, 16'h0000, 1'b0);
    push_beat(OP_STEP, 4'd15, 3'd0, 2'd0, 16'h0000, 1'b1);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin k = 16'h0000; nd = 3'd1; nc = 4'd1;  end
        1: begin k = 16'hFFFF; nd = 3'd4; nc = 4'd8;  end
        2: begin k = 16'd12345; nd = 3'd0; nc = 4'd0; end
        3: begin k = 16'd50000; nd = 3'd7; nc = 4'd15; end
        4: begin k = 16'd1;    nd = 3'd2; nc = 4'd9;  end
        5: begin k = 16'd40000; nd = 3'd3; nc = 4'd3; end
        6: begin k = 16'hFFFF; nd = 3'd5; nc = 4'd7;  end
        7: begin k = 16'h0000; nd = 3'd4; nc = 4'd8;  end
        default: begin k = 16'($urandom); nd = 3'($urandom); nc = 4'($urandom); end
      endcase
      if (p < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_SHRINK, k);
      write_reg(REG_DIMS, {13'($urandom), nd});
      write_reg(REG_CODES, {12'($urandom), nc});
      if (p == 3) write_reg(REG_NONE, 16'($urandom));
      queue_random(PHASE_LEN);
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== chaos_rep_nearest_codebook_top.f =====
hw/rtl/crnc_pkg.sv
hw/rtl/crnc_tables.sv
hw/rtl/chaos_rep_nearest_codebook_top.sv
dv/tb_chaos_rep_nearest_codebook_top.sv
